>>> rtl/core/retryable_error_phrase_matcher_defines.svh
// Assertion macros shared by the phrase matcher RTL.
// Each macro takes a label, the clock, the reset and the property or condition.
`ifndef RETRYABLE_ERROR_PHRASE_MATCHER_DEFINES_SVH
`define RETRYABLE_ERROR_PHRASE_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS

`define REPM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("phrase matcher assertion failed");

`define REPM_ASSERT_NEVER(label, clk, rst, cond) \
   `REPM_ASSERT(label, clk, rst, !(cond))

`else

`define REPM_ASSERT(label, clk, rst, prop)

`define REPM_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/core/repm_pkg.sv
package repm_pkg;

   localparam int HistoryBytesDefault = 35;
   localparam int PhraseCount = 27;
   localparam int PhraseMax = 36;

   // Phrases are right aligned: the last character sits in bits [7:0].
   localparam logic [PhraseMax*8-1:0] PhraseText [PhraseCount] = '{
      "handshake", "network error", "tls", "ssl", "eof", "unexpected eof",
      "connect failed", "connect error", "connection refused",
      "no route to host", "network is unreachable", "host is down",
      "connection reset", "broken pipe",
      "temporary failure in name resolution", "name or service not known",
      "nodename nor servname provided", "unknown host", "host not found",
      "timeout", "timed out",
      "partial file", "partial transfer", "truncated", "transfer closed",
      "outstanding read data remaining", "empty reply from server"
   };

   localparam int PhraseLen [PhraseCount] = '{
      9, 13, 3, 3, 3, 14,
      14, 13, 18,
      16, 22, 12,
      16, 11,
      36, 25,
      30, 12, 14,
      7, 9,
      12, 16, 9, 15,
      31, 23
   };

   localparam logic [7:0] UpperA = 8'h41;
   localparam logic [7:0] UpperZ = 8'h5a;
   localparam logic [7:0] CaseOffset = 8'h20;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       end_of_message;
   } item_type;

   typedef struct packed {
      logic [7:0] folded;
      logic       hit;
   } match_type;

endpackage

>>> rtl/core/repm_channels.sv
interface repm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output byte_value, output has_byte,
                   output end_of_message, input ready);
   modport sink (input valid, input byte_value, input has_byte,
                 input end_of_message, output ready);
endinterface

interface repm_rsp_if;
   logic valid;
   logic ready;
   logic retryable;

   modport source (output valid, output retryable, input ready);
   modport sink (input valid, input retryable, output ready);
endinterface

>>> rtl/core/repm_matcher.sv
module repm_matcher #(
   parameter int HistoryBytes = repm_pkg::HistoryBytesDefault
) (
   input  logic [7:0]                   byte_value,
   input  logic [HistoryBytes-1:0][7:0] window,
   output repm_pkg::match_type          result
);
   import repm_pkg::*;

   logic [7:0]             folded;
   logic [PhraseCount-1:0] phrase_hit;

   assign folded = (byte_value >= UpperA && byte_value <= UpperZ) ?
                   byte_value + CaseOffset : byte_value;

   // One comparator per phrase character; position 0 is the new byte,
   // position i is window entry i-1 (newest first).
   for (genvar k = 0; k < PhraseCount; k++) begin : g_phrase
      logic [PhraseMax-1:0] char_ok;
      for (genvar i = 0; i < PhraseMax; i++) begin : g_char
         if (i >= PhraseLen[k]) begin : g_pad
            assign char_ok[i] = 1'b1;
         end else if (i == 0) begin : g_new
            assign char_ok[i] = (folded == PhraseText[k][7:0]);
         end else if (i - 1 < HistoryBytes) begin : g_hist
            assign char_ok[i] = (window[i-1] == PhraseText[k][8*i +: 8]);
         end else begin : g_out
            assign char_ok[i] = 1'b0;
         end
      end
      if (PhraseLen[k] <= HistoryBytes + 1) begin : g_fits
         assign phrase_hit[k] = &char_ok;
      end else begin : g_long
         assign phrase_hit[k] = 1'b0;
      end
   end

   assign result.folded = folded;
   assign result.hit    = |phrase_hit;

endmodule

>>> rtl/core/repm_history.sv
`include "retryable_error_phrase_matcher_defines.svh"

module repm_history #(
   parameter int HistoryBytes = repm_pkg::HistoryBytesDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  repm_pkg::item_type           item,
   input  repm_pkg::match_type          match,
   output logic [HistoryBytes-1:0][7:0] window_ff,
   output logic                         flag
);
   import repm_pkg::*;

   logic [HistoryBytes-1:0][7:0] window_in;
   logic                         seen_ff;
   logic                         seen_in;

   // flag: sticky state including a hit on the byte now being retired
   assign flag = seen_ff || (item.has_byte && match.hit);

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (advance) begin
         if (item.end_of_message) begin
            window_in = '0;
            seen_in   = 1'b0;
         end else if (item.has_byte) begin
            window_in = {window_ff[HistoryBytes-2:0], match.folded};
            seen_in   = flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= 1'b0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

   `REPM_ASSERT(a_clear_after_last, clock, reset, (advance && item.end_of_message) |=> (!seen_ff && window_ff == '0))
   `REPM_ASSERT(a_hit_sticks, clock, reset, (advance && item.has_byte && match.hit && !item.end_of_message) |=> seen_ff)

endmodule

>>> rtl/core/retryable_error_phrase_matcher.sv
// A final word is registered in the input stage, then its result word in the output stage.
// Throughput: one request word per cycle, but for stalls of final words; the
// phrase compare is a single pass of parallel comparators against the history
// window. A final word stalls only while the previous result word is still unread.
// Reset (synchronous, active high) empties both stages, clears the window
// and the sticky match flag.
`include "retryable_error_phrase_matcher_defines.svh"

module retryable_error_phrase_matcher #(
   parameter int HistoryBytes = repm_pkg::HistoryBytesDefault
) (
   input logic       clock,
   input logic       reset,
   repm_req_if.sink  req_ch,
   repm_rsp_if.source rsp_ch
);
   import repm_pkg::*;

   // Input stage: holds one request word.
   logic     s1_valid_ff;
   logic     s1_valid_in;
   item_type s1_item_ff;
   logic     s1_go;
   logic     req_accept;

   // Output stage: holds one result word.
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_flag_ff;
   logic rsp_flag_in;

   logic [HistoryBytes-1:0][7:0] window;
   match_type                    match;
   logic                         flag;

   // The input stage retires when its word needs no result slot, or the
   // slot is free, or the slot empties this cycle.
   assign s1_go = s1_valid_ff &&
                  (!s1_item_ff.end_of_message || !rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.byte_value     <= req_ch.byte_value;
         s1_item_ff.has_byte       <= req_ch.has_byte;
         s1_item_ff.end_of_message <= req_ch.end_of_message;
      end
   end

   repm_matcher #(
      .HistoryBytes(HistoryBytes)
   ) u_matcher (
      .byte_value(s1_item_ff.byte_value),
      .window    (window),
      .result    (match)
   );

   repm_history #(
      .HistoryBytes(HistoryBytes)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_go),
      .item     (s1_item_ff),
      .match    (match),
      .window_ff(window),
      .flag     (flag)
   );

   // Result slot: loaded by a retiring final word, emptied when read.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (s1_go && s1_item_ff.end_of_message) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = flag;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.retryable = rsp_flag_ff;

   // A full, unread slot must hold back a pending final word.
   `REPM_ASSERT(a_last_waits, clock, reset, (s1_valid_ff && s1_item_ff.end_of_message && rsp_valid_ff && !rsp_ch.ready) |-> !s1_go)
   // A result only appears after a final word retired.
   `REPM_ASSERT(a_rsp_has_source, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_go && s1_item_ff.end_of_message))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import repm_pkg::*;

   localparam int HistDepth = repm_pkg::HistoryBytesDefault;
   localparam int PhraseTotal = 27;
   localparam int RandomWordTarget = 1850;
   localparam int TailQuietWords = 200;
   localparam int DrainCycles = 10;

   // Phrase list kept here independently of the RTL package.
   string retry_phrases [PhraseTotal] = '{
      "handshake", "network error", "tls", "ssl", "eof", "unexpected eof",
      "connect failed", "connect error", "connection refused",
      "no route to host", "network is unreachable", "host is down",
      "connection reset", "broken pipe",
      "temporary failure in name resolution", "name or service not known",
      "nodename nor servname provided", "unknown host", "host not found",
      "timeout", "timed out",
      "partial file", "partial transfer", "truncated", "transfer closed",
      "outstanding read data remaining", "empty reply from server"
   };

   typedef struct {
      item_type word;
      bit       drain_first;   // hold this word back until all results are in
   } stim_word_type;

   logic clock;
   logic reset;

   repm_req_if req_ch ();
   repm_rsp_if rsp_ch ();

   retryable_error_phrase_matcher u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Stimulus and scoreboard storage.
   stim_word_type pending_words [$];
   bit            expected_retryable [$];
   logic [7:0]    msg_bytes [$];

   // Mirror of the matcher: folded history, newest first, plus sticky hit.
   logic [7:0] history [HistDepth];
   bit         phrase_seen;

   int mismatches;
   int stim_words;
   int words_sent;
   int results_seen;
   int messages_done;
   int retryable_msgs;
   int drains_done;
   bit tail_quiet;

   // Driver state.
   stim_word_type cur_word;
   int            gap_left;
   bit            load_next;
   logic          next_valid;

   // Monitor state.
   int stall_left;
   int rsp_cycles;
   bit expected_flag;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // True when phrase p completes at byte c, the rest of it sitting in history.
   function automatic bit phrase_ends_here(string p, logic [7:0] c);
      int n;
      n = p.len();
      if (n == 0 || n > HistDepth + 1) return 1'b0;
      if (8'(p[n-1]) != c) return 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
         if (8'(p[n-2-i]) != history[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_word(item_type w);
      logic [7:0] c;
      bit         hit;
      c = fold_case(w.byte_value);
      if (w.has_byte) begin
         hit = 1'b0;
         foreach (retry_phrases[k]) begin
            if (phrase_ends_here(retry_phrases[k], c)) hit = 1'b1;
         end
         if (hit) phrase_seen = 1'b1;
         for (int i = HistDepth - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = c;
      end
      // Final word: byte (if any) is matched first, then the flag is reported.
      if (w.end_of_message) begin
         expected_retryable.push_back(phrase_seen);
         if (phrase_seen) retryable_msgs++;
         messages_done++;
         phrase_seen = 1'b0;
         foreach (history[i]) history[i] = 8'h00;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic add_word(logic [7:0] b, bit hb, bit eom, bit drain);
      stim_word_type s;
      s.word.byte_value = b;
      s.word.has_byte = hb;
      s.word.end_of_message = eom;
      s.drain_first = drain;
      pending_words.push_back(s);
      stim_words++;
   endtask

   // Sends a message as bytes; last byte carries the end mark unless split_end.
   task automatic add_text(string t, bit split_end);
      for (int i = 0; i < t.len(); i++)
         add_word(8'(t[i]), 1'b1, !split_end && (i == t.len() - 1), 1'b0);
      if (split_end) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
   endtask

   function automatic logic [7:0] random_case(logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - 8'd32;
      return c;
   endfunction

   task automatic push_phrase(string p, int keep, int mutate_at);
      logic [7:0] c;
      for (int i = 0; i < keep; i++) begin
         c = 8'(p[i]);
         if (i == mutate_at) c = 8'($urandom_range("a", "z"));
         msg_bytes.push_back(random_case(c));
      end
   endtask

   task automatic build_random_message();
      int    segs;
      int    kind;
      string p;
      msg_bytes.delete();
      segs = $urandom_range(0, 5);
      repeat (segs) begin
         kind = $urandom_range(0, 9);
         p = retry_phrases[$urandom_range(0, PhraseTotal - 1)];
         case (kind)
            0, 1: begin
               repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            2, 3: begin
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 5) == 0) msg_bytes.push_back(" ");
                  else msg_bytes.push_back(random_case(8'($urandom_range("a", "z"))));
               end
            end
            4, 5: begin
               push_phrase(p, p.len(), -1);
            end
            6: begin
               // near miss: phrase minus its last character
               push_phrase(p, p.len() - 1, -1);
            end
            7: begin
               push_phrase(p, p.len(), $urandom_range(0, p.len() - 1));
            end
            8: begin
               repeat ($urandom_range(30, 45)) msg_bytes.push_back(8'($urandom_range(32, 126)));
            end
            default: begin
               msg_bytes.push_back(8'($urandom_range(32, 64)));
            end
         endcase
      end
   endtask

   task automatic emit_message(bit drain);
      bit split_end;
      bit first;
      split_end = (msg_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
      first = 1'b1;
      foreach (msg_bytes[i]) begin
         // idle words between bytes must be ignored by the matcher
         if ($urandom_range(0, 15) == 0) begin
            add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, drain && first);
            first = 1'b0;
         end
         add_word(msg_bytes[i], 1'b1, !split_end && (i == msg_bytes.size() - 1),
                  drain && first);
         first = 1'b0;
      end
      if (split_end) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && first);
   endtask

   // Burst rate by region, so that some stretches run with no idling at all.
   function automatic int burst_pct(int n);
      case ((n / 80) % 4)
         0: return 0;
         1: return 8;
         2: return 25;
         default: return 50;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: one word per handshake, random gap bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
         phrase_seen = 1'b0;
         foreach (history[i]) history[i] = 8'h00;
      end else begin
         load_next = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            predict_word(cur_word.word);
            words_sent++;
            load_next = 1'b1;
         end else if (!req_ch.valid) begin
            load_next = 1'b1;
         end
         if (load_next) begin
            next_valid = 1'b0;
            tail_quiet = pending_words.size() < TailQuietWords;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() == 0) begin
               next_valid = 1'b0;
            end else if (pending_words[0].drain_first && expected_retryable.size() != 0) begin
               // hold off until the result pipe is empty
               next_valid = 1'b0;
            end else begin
               cur_word = pending_words.pop_front();
               if (cur_word.drain_first) drains_done++;
               req_ch.byte_value <= cur_word.word.byte_value;
               req_ch.has_byte <= cur_word.word.has_byte;
               req_ch.end_of_message <= cur_word.word.end_of_message;
               next_valid = 1'b1;
               if (!tail_quiet && $urandom_range(0, 99) < burst_pct(words_sent))
                  gap_left = $urandom_range(1, 12);
            end
            req_ch.valid <= next_valid;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and checker; ready drops in random stall bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         rsp_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_retryable.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result word, expected none actual %0b",
                        $time, rsp_ch.retryable);
            end else begin
               expected_flag = expected_retryable.pop_front();
               if (rsp_ch.retryable !== expected_flag) begin
                  mismatches++;
                  $display("%0t: retryable mismatch, expected %0b actual %0b",
                           $time, expected_flag, rsp_ch.retryable);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 99) < burst_pct(rsp_cycles / 3 + 40)) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.byte_value = 8'h00;
      req_ch.has_byte = 1'b0;
      req_ch.end_of_message = 1'b0;
      rsp_ch.ready = 1'b0;
      mismatches = 0;
      stim_words = 0;
      words_sent = 0;
      results_seen = 0;
      messages_done = 0;
      retryable_msgs = 0;
      drains_done = 0;
      tail_quiet = 1'b0;
      rsp_cycles = 0;

      // Directed words.
      add_word(8'h00, 1'b0, 1'b1, 1'b0);          // empty message
      add_word(8'hff, 1'b0, 1'b0, 1'b0);          // idle word, then empty message
      add_word(8'h00, 1'b0, 1'b1, 1'b0);
      add_text("TLS", 1'b0);                      // upper case, hit on final byte
      add_word(8'hff, 1'b1, 1'b1, 1'b0);          // single byte extremes
      add_word(8'h00, 1'b1, 1'b1, 1'b0);
      msg_bytes = '{"e", 8'h00, "o", "f"};        // zero byte breaks the phrase
      emit_message(1'b0);
      add_text("t", 1'b0);                        // no match across a boundary
      add_text("ls", 1'b0);
      add_text("sSl", 1'b1);                      // sticky hit reported on split end
      add_text("@[az", 1'b0);                     // case fold edges

      // Random messages; the first one waits for an empty result pipe.
      build_random_message();
      emit_message(1'b1);
      while (stim_words < RandomWordTarget) begin
         build_random_message();
         emit_message($urandom_range(0, 40) == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_words.size() != 0 || req_ch.valid || expected_retryable.size() != 0);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d words over %0d messages, %0d of them retryable.",
               words_sent, messages_done, retryable_msgs);
      $display("Checked %0d result words with gap and stall bursts; %0d drain pauses.",
               results_seen, drains_done);
      if (mismatches == 0 && expected_retryable.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
